### src/tfu_pkg.sv
`default_nettype none

package tfu_pkg;

	localparam int unsigned LOG_BYTES_DEF = 4096;

	typedef enum logic [1:0] {
		REQ_RAW = 2'd0,
		REQ_HEX = 2'd1,
		REQ_DEC = 2'd2
	} req_kind_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  char_byte;
		logic [31:0] value;
		logic [3:0]  hex_digits;
	} req_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [11:0] out_addr;
		logic        stored;
		logic [11:0] fill_level;
		logic        last_of_run;
	} rsp_t;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	// 'A' minus ten, so that a nibble of ten or more maps onto 'A'..'F'.
	localparam logic [7:0] ASCII_HEX_OFS = 8'h37;
	localparam logic [3:0] MAX_HEX = 4'd8;
	localparam logic [3:0] LAST_DEC = 4'd9;

	function automatic logic [31:0] dec_weight(input logic [3:0] idx);
		logic [31:0] w;
		case (idx)
			4'd0:    w = 32'd1000000000;
			4'd1:    w = 32'd100000000;
			4'd2:    w = 32'd10000000;
			4'd3:    w = 32'd1000000;
			4'd4:    w = 32'd100000;
			4'd5:    w = 32'd10000;
			4'd6:    w = 32'd1000;
			4'd7:    w = 32'd100;
			4'd8:    w = 32'd10;
			default: w = 32'd1;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = ASCII_ZERO + 8'(nib);
		end else begin
			c = ASCII_HEX_OFS + 8'(nib);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### src/tfu_stream_if.sv
`default_nettype none

interface tfu_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/trace_text_formatter_unit.sv
// Channel | Role   | Word
// req     | sink   | tfu_pkg::req_t: req_type, char_byte, value, hex_digits
// rsp     | source | tfu_pkg::rsp_t: out_byte, out_addr, stored, fill_level, last_of_run
//
// A request is taken only while the sequencer is idle; each produced byte goes
// through one output register. Decimal digits are found by the single
// compare-and-subtract unit, which subtracts one weight from the value per cycle.
// A stalled rsp holds the sequencer wherever the next byte is due.
// arst_n clears the sequencer, the output valid and the write pointer.
`default_nettype none

module trace_text_formatter_unit #(
	parameter int unsigned LOG_BYTES = tfu_pkg::LOG_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	tfu_stream_if.sink   req,
	tfu_stream_if.source rsp
);

	localparam int PW = $clog2(LOG_BYTES);
	localparam int EW = (PW > 12) ? PW : 12;

	typedef enum logic [1:0] {S_IDLE, S_RAW, S_HEX, S_DEC} state_t;

	state_t         state_q;
	logic [31:0]    val_q;
	logic [7:0]     byte_q;
	logic [3:0]     cnt_q;
	logic [3:0]     q_q;
	logic           started_q;
	logic [PW-1:0]  ptr_q;
	tfu_pkg::rsp_t  out_q;
	logic           out_valid_q;

	logic           can_emit;
	logic [31:0]    weight;
	logic           ge;
	logic [31:0]    diff;
	logic           dec_show;
	logic           emit_en;
	logic [7:0]     emit_byte;
	logic           emit_last;
	logic           full;
	logic [PW-1:0]  ptr_nx;
	logic [EW-1:0]  addr_ext;
	logic [EW-1:0]  fill_ext;
	logic [3:0]     hex_n;
	logic [4:0]     hex_sh;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign can_emit = !out_valid_q || rsp.ready;
	assign weight   = tfu_pkg::dec_weight(cnt_q);
	assign ge       = (val_q >= weight);
	assign diff     = val_q - weight;
	assign dec_show = (q_q != 4'd0) || started_q || (cnt_q == tfu_pkg::LAST_DEC);

	assign full     = (ptr_q == PW'(LOG_BYTES - 1));
	assign ptr_nx   = full ? ptr_q : ptr_q + 1'b1;
	assign addr_ext = EW'(ptr_q);
	assign fill_ext = EW'(ptr_nx);

	// The first digit to show is moved to the top nibble, then shifted out.
	assign hex_n  = (req.data.hex_digits > tfu_pkg::MAX_HEX) ? tfu_pkg::MAX_HEX
	                                                          : req.data.hex_digits;
	assign hex_sh = 5'({tfu_pkg::MAX_HEX - hex_n, 2'b00});

	always_comb begin
		emit_en   = 1'b0;
		emit_byte = byte_q;
		emit_last = 1'b0;
		case (state_q)
			S_RAW: begin
				emit_en   = can_emit;
				emit_byte = byte_q;
				emit_last = 1'b1;
			end
			S_HEX: begin
				emit_en   = can_emit;
				emit_byte = tfu_pkg::hex_char(val_q[31:28]);
				emit_last = (cnt_q == 4'd1);
			end
			S_DEC: begin
				emit_en   = !ge && dec_show && can_emit;
				emit_byte = tfu_pkg::ASCII_ZERO + 8'(q_q);
				emit_last = (cnt_q == tfu_pkg::LAST_DEC);
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ptr_q       <= '0;
		end else begin
			if (emit_en) begin
				out_q.out_byte    <= emit_byte;
				out_q.out_addr    <= addr_ext[11:0];
				out_q.stored      <= !full;
				out_q.fill_level  <= fill_ext[11:0];
				out_q.last_of_run <= emit_last;
				out_valid_q       <= 1'b1;
				ptr_q             <= ptr_nx;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						case (req.data.req_type)
							tfu_pkg::REQ_RAW: begin
								byte_q  <= req.data.char_byte;
								state_q <= S_RAW;
							end
							tfu_pkg::REQ_HEX: begin
								if (req.data.hex_digits != 4'd0) begin
									cnt_q   <= hex_n;
									val_q   <= req.data.value << hex_sh;
									state_q <= S_HEX;
								end
							end
							tfu_pkg::REQ_DEC: begin
								val_q     <= req.data.value;
								cnt_q     <= 4'd0;
								q_q       <= 4'd0;
								started_q <= 1'b0;
								state_q   <= S_DEC;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RAW: begin
					if (emit_en) begin
						state_q <= S_IDLE;
					end
				end
				S_HEX: begin
					if (emit_en) begin
						val_q <= {val_q[27:0], 4'h0};
						cnt_q <= cnt_q - 4'd1;
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DEC: begin
					if (ge) begin
						val_q <= diff;
						q_q   <= q_q + 4'd1;
					end else if (!dec_show || can_emit) begin
						// Digit for this weight is settled; leading zeros pass silently.
						if (dec_show) begin
							started_q <= 1'b1;
						end
						q_q <= 4'd0;
						if (cnt_q == tfu_pkg::LAST_DEC) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_stored: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.stored |-> rsp.data.fill_level == rsp.data.out_addr + 12'd1)
		else $error("stored byte does not advance the fill level by one");

	a_fill_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.stored |-> rsp.data.fill_level == rsp.data.out_addr)
		else $error("dropped byte changed the fill level");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PW'(LOG_BYTES - 1))
		else $error("write pointer passed the terminator slot");

	a_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEC |-> q_q <= 4'd9)
		else $error("decimal digit count exceeded nine");

	a_hex_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HEX |-> cnt_q != 4'd0 && cnt_q <= tfu_pkg::MAX_HEX)
		else $error("hex digit count out of range");

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LOG_BYTES = tfu_pkg::LOG_BYTES_DEF;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned IDLE_PCT = 17;
	localparam int unsigned SETTLE_CYCLES = 200;
	localparam logic [8*16-1:0] HEX_SET = "0123456789ABCDEF";

	logic clk = 1'b0;
	logic arst_n;

	tfu_stream_if #(.payload_t(tfu_pkg::req_t)) req_bus ();
	tfu_stream_if #(.payload_t(tfu_pkg::rsp_t)) rsp_bus ();

	trace_text_formatter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	tfu_pkg::rsp_t byte_q[$];
	int unsigned fill_ptr = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	bit no_idle = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Works out the bytes one accepted request should produce and the log
	// position of each, advancing the fill pointer as the block would.
	function automatic void format_request(input tfu_pkg::req_t r);
		logic [7:0] digs[10];
		logic [7:0] rev[10];
		logic [31:0] v;
		logic [3:0] nd;
		tfu_pkg::rsp_t want;
		int n;
		int m;
		n = 0;
		m = 0;
		v = r.value;
		case (r.req_type)
			tfu_pkg::REQ_RAW: begin
				digs[0] = r.char_byte;
				n = 1;
			end
			tfu_pkg::REQ_HEX: begin
				nd = (r.hex_digits > tfu_pkg::MAX_HEX) ? tfu_pkg::MAX_HEX : r.hex_digits;
				for (int i = int'(nd) - 1; i >= 0; i--) begin
					digs[n] = HEX_SET[8 * (15 - int'(v[4 * i +: 4])) +: 8];
					n++;
				end
			end
			tfu_pkg::REQ_DEC: begin
				do begin
					rev[m] = tfu_pkg::ASCII_ZERO + 8'(v % 32'd10);
					v = v / 32'd10;
					m++;
				end while (v != 32'd0);
				for (int i = m - 1; i >= 0; i--) begin
					digs[n] = rev[i];
					n++;
				end
			end
			default: n = 0;
		endcase
		for (int k = 0; k < n; k++) begin
			want.out_byte = digs[k];
			want.out_addr = 12'(fill_ptr);
			want.stored = (fill_ptr < LOG_BYTES - 1);
			if (want.stored) begin
				fill_ptr++;
			end
			want.fill_level = 12'(fill_ptr);
			want.last_of_run = (k == n - 1);
			byte_q.push_back(want);
		end
	endfunction

	function automatic tfu_pkg::req_t make_req(input logic [1:0] kind, input logic [7:0] ch,
			input logic [31:0] val, input logic [3:0] nd);
		tfu_pkg::req_t r;
		r.req_type = kind;
		r.char_byte = ch;
		r.value = val;
		r.hex_digits = nd;
		return r;
	endfunction

	function automatic tfu_pkg::req_t random_req();
		tfu_pkg::req_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		r = make_req(tfu_pkg::REQ_RAW, 8'($urandom), $urandom, 4'($urandom_range(8, 1)));
		if (pick < 6) begin
			r.req_type = REQ_UNUSED;
			r.hex_digits = 4'($urandom);
		end else if (pick < 9) begin
			r.req_type = tfu_pkg::REQ_HEX;
			r.hex_digits = 4'd0;
		end else if (pick < 38) begin
			r.req_type = tfu_pkg::REQ_RAW;
		end else if (pick < 68) begin
			r.req_type = tfu_pkg::REQ_HEX;
			if ($urandom_range(99) < 15) begin
				r.hex_digits = 4'($urandom_range(15, 9));
			end
		end else begin
			r.req_type = tfu_pkg::REQ_DEC;
			// Shorter values give every digit count, not just ten digits.
			if ($urandom_range(1)) begin
				r.value = r.value >> $urandom_range(31);
			end
		end
		return r;
	endfunction

	task automatic send_req(input tfu_pkg::req_t r);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.data <= r;
		@(posedge clk);
		while (!req_bus.ready) begin
			@(posedge clk);
		end
		format_request(r);
	endtask

	task automatic drain();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (byte_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_raw_chars();
		send_req(make_req(tfu_pkg::REQ_RAW, 8'h00, 32'h0, 4'd0));
		send_req(make_req(tfu_pkg::REQ_RAW, 8'hFF, 32'hFFFFFFFF, 4'd15));
		send_req(make_req(tfu_pkg::REQ_RAW, 8'h41, $urandom, 4'($urandom)));
		send_req(make_req(tfu_pkg::REQ_RAW, 8'h0A, $urandom, 4'($urandom)));
		drain();
	endtask

	task automatic test_hex_values();
		send_req(make_req(tfu_pkg::REQ_HEX, 8'h00, 32'hFFFFFFFF, 4'd8));
		send_req(make_req(tfu_pkg::REQ_HEX, 8'hFF, 32'h00000000, 4'd1));
		send_req(make_req(tfu_pkg::REQ_HEX, 8'h00, 32'h12345678, 4'd8));
		send_req(make_req(tfu_pkg::REQ_HEX, 8'h00, 32'hDEADBEEF, 4'd3));
		// No digits asked for: nothing comes out.
		send_req(make_req(tfu_pkg::REQ_HEX, 8'h00, 32'h89ABCDEF, 4'd0));
		send_req(make_req(tfu_pkg::REQ_HEX, 8'h00, 32'hA5A5A5A5, 4'd15));
		send_req(make_req(tfu_pkg::REQ_HEX, 8'h00, 32'h0F1E2D3C, 4'd9));
		drain();
	endtask

	task automatic test_decimal_values();
		send_req(make_req(tfu_pkg::REQ_DEC, 8'h00, 32'd0, 4'd0));
		send_req(make_req(tfu_pkg::REQ_DEC, 8'hFF, 32'd9, 4'd15));
		send_req(make_req(tfu_pkg::REQ_DEC, 8'h00, 32'd10, 4'd0));
		send_req(make_req(tfu_pkg::REQ_DEC, 8'h00, 32'hFFFFFFFF, 4'd0));
		send_req(make_req(tfu_pkg::REQ_DEC, 8'h00, 32'd1000000000, 4'd0));
		send_req(make_req(tfu_pkg::REQ_DEC, 8'h00, 32'd999999999, 4'd0));
		send_req(make_req(tfu_pkg::REQ_DEC, 8'h00, 32'd100, 4'd0));
		drain();
	endtask

	task automatic test_unused_type();
		send_req(make_req(REQ_UNUSED, 8'hFF, 32'hFFFFFFFF, 4'd15));
		send_req(make_req(REQ_UNUSED, 8'h00, 32'h0, 4'd0));
		send_req(make_req(tfu_pkg::REQ_RAW, 8'h5A, 32'h0, 4'd0));
		drain();
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 80; i++) begin
			no_idle = (i >= 20 && i < 50);
			if (i == 60) begin
				drain();
			end
			send_req(random_req());
		end
		no_idle = 1'b0;
		drain();
	endtask

	// Runs the log up to its terminator slot with ten-digit values, then
	// keeps writing past it.
	task automatic test_full_log();
		while (fill_ptr < LOG_BYTES - 1) begin
			send_req(make_req(tfu_pkg::REQ_DEC, 8'($urandom),
				$urandom_range(32'hFFFFFFFF, 32'd1000000000), 4'($urandom)));
		end
		for (int i = 0; i < 20; i++) begin
			send_req(random_req());
		end
		drain();
	endtask

	always @(negedge clk) begin
		rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : check_bytes
		tfu_pkg::rsp_t want;
		tfu_pkg::rsp_t got;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			got = rsp_bus.data;
			if (byte_q.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected word at cycle %0d: byte %h addr %0d", cycles,
						got.out_byte, got.out_addr);
				end
			end else begin
				want = byte_q.pop_front();
				if (got.out_byte !== want.out_byte || got.out_addr !== want.out_addr ||
						got.stored !== want.stored || got.fill_level !== want.fill_level ||
						got.last_of_run !== want.last_of_run) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch at cycle %0d: expected byte %h addr %0d stored %b",
							cycles, want.out_byte, want.out_addr, want.stored,
							" fill %0d last %b", want.fill_level, want.last_of_run);
						$display("    got byte %h addr %0d stored %b fill %0d last %b",
							got.out_byte, got.out_addr, got.stored, got.fill_level,
							got.last_of_run);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d words outstanding", byte_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.data = '0;
		rsp_bus.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_raw_chars();
		test_hex_values();
		test_decimal_values();
		test_unused_type();
		test_random_mix();
		test_full_log();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && byte_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

`default_nettype wire

### sim.f
src/tfu_pkg.sv
src/tfu_stream_if.sv
src/trace_text_formatter_unit.sv
tb/tb_top.sv
